[rtl/core/cell_tap_averager_with_count_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the tap averager
// Concurrent checks that are compiled in unless ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef CELL_TAP_AVERAGER_WITH_COUNT_MACROS_SVH
`define CELL_TAP_AVERAGER_WITH_COUNT_MACROS_SVH

`ifndef ASSERT_OFF
// Whenever ante holds, cons must hold in the same cycle.
`define ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// The condition must never hold.
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, ante, cons)
`define ASSERT_NEVER(lbl, cond)
`endif

`endif

[rtl/core/ctac_pkg.sv]
// ----------------------------------------------------------------------------
// Tap averager package
// Shared widths, window constants, reciprocals and register codes.
// ----------------------------------------------------------------------------
package ctac_pkg;

  localparam int NUM_CH      = 6;
  localparam int NUM_LONG    = 4;
  localparam int CH_W        = 3;
  localparam int SAMPLE_W    = 10;
  localparam int SCALE_W     = 16;
  localparam int MV_W        = 16;
  localparam int COUNT_W     = 3;
  localparam int CFG_ADDR_W  = 5;
  localparam int CFG_DATA_W  = 32;
  localparam int PROD1_W     = SAMPLE_W + SCALE_W;

  localparam int LONG_WINDOW  = 10;
  localparam int SHORT_WINDOW = 3;
  localparam int MAX_WINDOW   = (LONG_WINDOW > SHORT_WINDOW) ? LONG_WINDOW : SHORT_WINDOW;
  localparam int LONG_TAPS    = LONG_WINDOW - 1;
  localparam int SHORT_TAPS   = SHORT_WINDOW - 1;
  localparam int MAX_TAPS     = MAX_WINDOW - 1;

  // Window sums and the reciprocal multiply used for the constant divide.
  localparam int SUM_W       = MV_W + $clog2(MAX_WINDOW);
  localparam int RECIP_W     = SUM_W + 1;
  localparam int PROD_W      = SUM_W + RECIP_W;
  localparam int LONG_SHIFT  = SUM_W + $clog2(LONG_WINDOW);
  localparam int SHORT_SHIFT = SUM_W + $clog2(SHORT_WINDOW);
  localparam logic [RECIP_W-1:0] LONG_RECIP =
    RECIP_W'(((64'd1 << LONG_SHIFT) + LONG_WINDOW - 1) / LONG_WINDOW);
  localparam logic [RECIP_W-1:0] SHORT_RECIP =
    RECIP_W'(((64'd1 << SHORT_SHIFT) + SHORT_WINDOW - 1) / SHORT_WINDOW);

  // Cell count thresholds in millivolts.
  localparam logic [MV_W-1:0] CELL3_MV = 16'd8000;
  localparam logic [MV_W-1:0] CELL4_MV = 16'd11000;
  localparam logic [MV_W-1:0] CELL5_MV = 16'd14000;
  localparam logic [MV_W-1:0] CELL6_MV = 16'd17000;
  localparam logic [COUNT_W-1:0] CELLS_2 = 3'd2;
  localparam logic [COUNT_W-1:0] CELLS_3 = 3'd3;
  localparam logic [COUNT_W-1:0] CELLS_4 = 3'd4;
  localparam logic [COUNT_W-1:0] CELLS_5 = 3'd5;
  localparam logic [COUNT_W-1:0] CELLS_6 = 3'd6;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;

  typedef enum logic [2:0] {
    REG_SCALE_CH1 = 3'd0,
    REG_SCALE_CH2 = 3'd1,
    REG_SCALE_CH3 = 3'd2,
    REG_SCALE_CH4 = 3'd3,
    REG_SCALE_CH5 = 3'd4,
    REG_SCALE_CH6 = 3'd5
  } cfg_idx_t;

  typedef logic [NUM_CH-1:0][MV_W-1:0]    lane_vec_t;
  typedef logic [NUM_CH-1:0][SCALE_W-1:0] scale_vec_t;

endpackage

[rtl/core/ctac_tap_cell.sv]
// ----------------------------------------------------------------------------
// Tap cell
// One history position for every channel; a lane takes its neighbour's value
// when that channel's history moves on.
// ----------------------------------------------------------------------------
module ctac_tap_cell import ctac_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [NUM_CH-1:0] shift_en,
  input  lane_vec_t         tap_in,
  output lane_vec_t         tap_out
);

  lane_vec_t tap_r;
  lane_vec_t tap_nxt;

  always_comb begin
    tap_nxt = tap_r;
    for (int c = 0; c < NUM_CH; c++) begin
      if (shift_en[c]) begin
        tap_nxt[c] = tap_in[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_r <= '0;
    end else begin
      tap_r <= tap_nxt;
    end
  end

  assign tap_out = tap_r;

endmodule

[rtl/core/ctac_cfg_regs.sv]
// ----------------------------------------------------------------------------
// Configuration registers
// Six per-channel scale coefficients behind a simple APB-style port.
// ----------------------------------------------------------------------------
module ctac_cfg_regs import ctac_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output scale_vec_t            scale
);

  scale_vec_t scale_r;
  scale_vec_t scale_nxt;
  cfg_idx_t   idx;
  logic       wr;

  assign idx = cfg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign wr  = psel && penable && pwrite;

  always_comb begin
    scale_nxt = scale_r;
    prdata    = '0;
    case (idx)
      REG_SCALE_CH1: begin
        prdata = CFG_DATA_W'(scale_r[0]);
        if (wr) scale_nxt[0] = pwdata[SCALE_W-1:0];
      end
      REG_SCALE_CH2: begin
        prdata = CFG_DATA_W'(scale_r[1]);
        if (wr) scale_nxt[1] = pwdata[SCALE_W-1:0];
      end
      REG_SCALE_CH3: begin
        prdata = CFG_DATA_W'(scale_r[2]);
        if (wr) scale_nxt[2] = pwdata[SCALE_W-1:0];
      end
      REG_SCALE_CH4: begin
        prdata = CFG_DATA_W'(scale_r[3]);
        if (wr) scale_nxt[3] = pwdata[SCALE_W-1:0];
      end
      REG_SCALE_CH5: begin
        prdata = CFG_DATA_W'(scale_r[4]);
        if (wr) scale_nxt[4] = pwdata[SCALE_W-1:0];
      end
      REG_SCALE_CH6: begin
        prdata = CFG_DATA_W'(scale_r[5]);
        if (wr) scale_nxt[5] = pwdata[SCALE_W-1:0];
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= {NUM_CH{SCALE_RESET}};
    end else begin
      scale_r <= scale_nxt;
    end
  end

  assign scale = scale_r;

endmodule

[rtl/core/cell_tap_averager_with_count.sv]
// ----------------------------------------------------------------------------
// Multichannel tap averager with cell count
// Scales tagged converter samples to millivolts, averages them per channel
// and reports the detected cell count.
// ----------------------------------------------------------------------------
// The block accepts one transfer per clock while in_tready is high and
// returns one result transfer for every input transfer, in order, through
// stages 1 to 4. The rate is set by the per-channel window update:
// each channel keeps a running sum of its history, and one add and one
// subtract per cycle bring it up to date, so consecutive samples of the same
// channel follow each other without a gap. The history itself lives in a
// row of tap cells, each cell holding one age position for all six channels;
// the newest scaled value enters the first cell and the selected channel's
// lane moves one cell along. The four stages are: scale multiply and
// saturation, window update, reciprocal multiply for the constant divide,
// and a final stage that picks the quotient, records the latest averages of
// channels 3 to 6 and forms the cell count from them, including the current
// result. Channel codes 6 and 7 change no state and give an average of zero.
// Stages collapse bubbles, so input is still taken while a result waits at
// the output as long as some stage is empty.
// ----------------------------------------------------------------------------
`include "cell_tap_averager_with_count_macros.svh"

module cell_tap_averager_with_count import ctac_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input stream.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [15:0]           in_tdata,   // [9:0] sample, rest zero
  input  logic [CH_W-1:0]       in_tuser,   // [2:0] channel
  // Result stream.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [23:0]           out_tdata,  // [15:0] average_mv, [18:16] cell_count
  output logic [CH_W-1:0]       out_tuser,  // [2:0] channel_out
  // Configuration port.
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  scale_vec_t scale;

  ctac_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .scale   (scale)
  );

  assign cfg_pready = 1'b1;

  // ---------------------------------------------------------------------------
  // Stage control: each stage may load when it is empty or its content moves
  // on, so bubbles are squeezed out while the output is held.
  // ---------------------------------------------------------------------------
  logic v1_r, v2_r, v3_r, v4_r;
  logic take1, take2, take3, take4;

  assign take4 = !v4_r || out_tready;
  assign take3 = !v3_r || take4;
  assign take2 = !v2_r || take3;
  assign take1 = !v1_r || take2;

  assign in_tready = take1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (take1) v1_r <= in_tvalid;
      if (take2) v2_r <= v1_r;
      if (take3) v3_r <= v2_r;
      if (take4) v4_r <= v3_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: select the channel's coefficient, multiply and saturate.
  // ---------------------------------------------------------------------------
  logic [SCALE_W-1:0]  scale_sel;
  logic [PROD1_W-1:0]  prod1;
  logic [MV_W-1:0]     mv_sat;
  logic [CH_W-1:0]     ch1_r;
  logic [MV_W-1:0]     mv1_r;

  always_comb begin
    scale_sel = scale[NUM_CH-1];
    for (int c = 0; c < NUM_CH; c++) begin
      if (in_tuser == CH_W'(c)) begin
        scale_sel = scale[c];
      end
    end
  end

  assign prod1  = PROD1_W'(in_tdata[SAMPLE_W-1:0]) * PROD1_W'(scale_sel);
  // Anything at or above 2^24 after the Q8.8 multiply exceeds 16 bits of mV.
  assign mv_sat = (|prod1[PROD1_W-1:MV_W+8]) ? {MV_W{1'b1}} : prod1[MV_W+7:8];

  always_ff @(posedge clk) begin
    if (in_tvalid && take1) begin
      ch1_r <= in_tuser;
      mv1_r <= mv_sat;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: window update. The running sum holds the stored taps; the new
  // total adds the fresh value, and the oldest tap drops out of the sum as the
  // history moves on.
  // ---------------------------------------------------------------------------
  lane_vec_t          chain_tap [MAX_TAPS];
  lane_vec_t          fresh_lanes;
  logic [NUM_CH-1:0]  shift_en;
  logic [SUM_W-1:0]   run_sum_r   [NUM_CH];
  logic [SUM_W-1:0]   run_sum_nxt [NUM_CH];
  logic [SUM_W-1:0]   run_sel;
  logic [MV_W-1:0]    oldest;
  logic               tap_ch;
  logic [SUM_W-1:0]   total;
  logic [CH_W-1:0]    ch2_r;
  logic [SUM_W-1:0]   total2_r;

  assign fresh_lanes = {NUM_CH{mv1_r}};

  for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
    if (k == 0) begin : g_head
      ctac_tap_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (shift_en),
        .tap_in   (fresh_lanes),
        .tap_out  (chain_tap[k])
      );
    end else begin : g_body
      ctac_tap_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (shift_en),
        .tap_in   (chain_tap[k-1]),
        .tap_out  (chain_tap[k])
      );
    end
  end

  always_comb begin
    run_sel = '0;
    oldest  = '0;
    tap_ch  = 1'b0;
    for (int c = 0; c < NUM_CH; c++) begin
      if (ch1_r == CH_W'(c)) begin
        tap_ch  = 1'b1;
        run_sel = run_sum_r[c];
        // Long-window channels drop their tap at the far end of the row;
        // the short-window channels only use the first few cells.
        oldest  = (c < NUM_LONG) ? chain_tap[LONG_TAPS-1][c] : chain_tap[SHORT_TAPS-1][c];
      end
    end
    total = tap_ch ? (run_sel + SUM_W'(mv1_r)) : '0;
    for (int c = 0; c < NUM_CH; c++) begin
      shift_en[c]    = v1_r && take2 && (ch1_r == CH_W'(c));
      run_sum_nxt[c] = shift_en[c] ? (total - SUM_W'(oldest)) : run_sum_r[c];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_CH; c++) begin
        run_sum_r[c] <= '0;
      end
    end else begin
      for (int c = 0; c < NUM_CH; c++) begin
        run_sum_r[c] <= run_sum_nxt[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (v1_r && take2) begin
      ch2_r    <= ch1_r;
      total2_r <= total;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: divide by the window size as a multiply by its reciprocal.
  // ---------------------------------------------------------------------------
  logic               long2;
  logic [CH_W-1:0]    ch3_r;
  logic               long3_r;
  logic [PROD_W-1:0]  prod3_r;

  assign long2 = (ch2_r < CH_W'(NUM_LONG));

  always_ff @(posedge clk) begin
    if (v2_r && take3) begin
      ch3_r   <= ch2_r;
      long3_r <= long2;
      prod3_r <= PROD_W'(total2_r) * PROD_W'(long2 ? LONG_RECIP : SHORT_RECIP);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: take the quotient, keep the latest averages of channels 3 to 6
  // and derive the cell count with this result already included.
  // ---------------------------------------------------------------------------
  logic [MV_W-1:0]    avg3;
  logic [MV_W-1:0]    latest_r   [4];
  logic [MV_W-1:0]    latest_nxt [4];
  logic [COUNT_W-1:0] cells;
  logic [CH_W-1:0]    ch4_r;
  logic [MV_W-1:0]    avg4_r;
  logic [COUNT_W-1:0] cells4_r;

  assign avg3 = long3_r ? prod3_r[LONG_SHIFT +: MV_W] : prod3_r[SHORT_SHIFT +: MV_W];

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      latest_nxt[j] = latest_r[j];
      if (v3_r && take4 && (ch3_r == CH_W'(j + 2))) begin
        latest_nxt[j] = avg3;
      end
    end
    if (latest_nxt[3] > CELL6_MV) begin
      cells = CELLS_6;
    end else if (latest_nxt[2] > CELL5_MV) begin
      cells = CELLS_5;
    end else if (latest_nxt[1] > CELL4_MV) begin
      cells = CELLS_4;
    end else if (latest_nxt[0] > CELL3_MV) begin
      cells = CELLS_3;
    end else begin
      cells = CELLS_2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < 4; j++) begin
        latest_r[j] <= '0;
      end
    end else begin
      for (int j = 0; j < 4; j++) begin
        latest_r[j] <= latest_nxt[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (v3_r && take4) begin
      ch4_r    <= ch3_r;
      avg4_r   <= avg3;
      cells4_r <= cells;
    end
  end

  assign out_tvalid = v4_r;
  assign out_tuser  = ch4_r;
  assign out_tdata  = {5'b0, cells4_r, avg4_r};

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `ASSERT_IMPLY(a_stall_only_from_output, !in_tready, out_tvalid && !out_tready)
  `ASSERT_NEVER(a_cells_in_range, out_tvalid && (cells4_r < CELLS_2 || cells4_r > CELLS_6))
  `ASSERT_IMPLY(a_unused_channel_zero, out_tvalid && (out_tuser > CH_W'(NUM_CH - 1)),
                avg4_r == '0)

endmodule

[test/tap_average_checker.sv]
// ----------------------------------------------------------------------------
// Tap averager result checker
// Watches the input, result and register transfers of the averager, predicts
// each result from its own copy of the scales and window histories, and
// compares every result transfer with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module tap_average_checker import ctac_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [15:0]           in_tdata,
  input  logic [CH_W-1:0]       in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [23:0]           out_tdata,
  input  logic [CH_W-1:0]       out_tuser,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  input  logic                  cfg_pready,
  output int                    failures,
  output int                    pending
);

  typedef struct packed {
    logic [CH_W-1:0]    channel;
    logic [MV_W-1:0]    average_mv;
    logic [COUNT_W-1:0] cells;
  } tap_result_t;

  logic [SCALE_W-1:0] scale      [NUM_CH];
  logic [MV_W-1:0]    long_taps  [NUM_LONG][LONG_TAPS];
  logic [MV_W-1:0]    short_taps [NUM_CH-NUM_LONG][SHORT_TAPS];
  logic [MV_W-1:0]    kept_avg   [4];

  tap_result_t expected_averages[$];
  int fail_total = 0;
  int in_flight  = 0;

  assign failures = fail_total;
  assign pending  = in_flight;

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    fail_total++;
  endtask

  // Scales the sample, slides it into the channel's window and returns the
  // result the block should give, updating the kept averages on the way.
  function automatic tap_result_t predict_tap_result(logic [CH_W-1:0] ch,
                                                     logic [SAMPLE_W-1:0] smp);
    tap_result_t        res;
    logic [PROD1_W-1:0] prod;
    logic [PROD1_W-1:0] shifted;
    logic [MV_W-1:0]    mv;
    int unsigned        total;
    int                 lane;
    res.channel    = ch;
    res.average_mv = '0;
    if (ch < NUM_CH) begin
      prod    = smp * scale[ch];
      shifted = prod >> 8;
      mv      = (shifted > {{(PROD1_W-MV_W){1'b0}}, {MV_W{1'b1}}}) ? '1 : shifted[MV_W-1:0];
      total   = mv;
      if (ch < NUM_LONG) begin
        for (int i = 0; i < LONG_TAPS; i++) total += long_taps[ch][i];
        for (int i = 0; i < LONG_TAPS - 1; i++) long_taps[ch][i] = long_taps[ch][i+1];
        long_taps[ch][LONG_TAPS-1] = mv;
        res.average_mv = MV_W'(total / LONG_WINDOW);
      end else begin
        lane = ch - NUM_LONG;
        for (int i = 0; i < SHORT_TAPS; i++) total += short_taps[lane][i];
        for (int i = 0; i < SHORT_TAPS - 1; i++) short_taps[lane][i] = short_taps[lane][i+1];
        short_taps[lane][SHORT_TAPS-1] = mv;
        res.average_mv = MV_W'(total / SHORT_WINDOW);
      end
      if (ch >= 2) kept_avg[ch-2] = res.average_mv;
    end
    // The highest channel over its threshold wins.
    if (kept_avg[3] > CELL6_MV)      res.cells = CELLS_6;
    else if (kept_avg[2] > CELL5_MV) res.cells = CELLS_5;
    else if (kept_avg[1] > CELL4_MV) res.cells = CELLS_4;
    else if (kept_avg[0] > CELL3_MV) res.cells = CELLS_3;
    else                             res.cells = CELLS_2;
    return res;
  endfunction

  always @(posedge clk) begin
    tap_result_t want;
    if (!rst_n) begin
      for (int c = 0; c < NUM_CH; c++) scale[c] = SCALE_RESET;
      for (int c = 0; c < NUM_LONG; c++)
        for (int i = 0; i < LONG_TAPS; i++) long_taps[c][i] = '0;
      for (int c = 0; c < NUM_CH - NUM_LONG; c++)
        for (int i = 0; i < SHORT_TAPS; i++) short_taps[c][i] = '0;
      for (int c = 0; c < 4; c++) kept_avg[c] = '0;
      expected_averages.delete();
    end else begin
      // The bench must make register writes only while nothing is in flight; the checker does not enforce it.
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr[1:0] == 2'b00 &&
          cfg_paddr[CFG_ADDR_W-1:2] <= REG_SCALE_CH6)
        scale[cfg_paddr[CFG_ADDR_W-1:2]] = cfg_pwdata[SCALE_W-1:0];
      if (in_tvalid && in_tready)
        expected_averages.push_back(predict_tap_result(in_tuser, in_tdata[SAMPLE_W-1:0]));
      if (out_tvalid && out_tready) begin
        if (expected_averages.size() == 0) begin
          report_mismatch("unexpected result, average", 0, out_tdata[MV_W-1:0]);
        end else begin
          want = expected_averages.pop_front();
          if (out_tuser !== want.channel)
            report_mismatch("channel", want.channel, out_tuser);
          if (out_tdata[MV_W-1:0] !== want.average_mv)
            report_mismatch("average_mv", want.average_mv, out_tdata[MV_W-1:0]);
          if (out_tdata[MV_W+COUNT_W-1:MV_W] !== want.cells)
            report_mismatch("cell_count", want.cells, out_tdata[MV_W+COUNT_W-1:MV_W]);
        end
      end
    end
    in_flight <= expected_averages.size();
  end

endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// Tap averager regression
// Drives tagged converter samples and scale register writes into the averager
// under random source gaps and sink stalls; a separate checker predicts and
// compares every result, and this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  import ctac_pkg::*;

  // Tap channel codes as they travel on in_tuser; the last two are unused
  // codes which must leave all state alone.
  localparam logic [CH_W-1:0] TAP_CH1    = 3'd0;
  localparam logic [CH_W-1:0] TAP_CH2    = 3'd1;
  localparam logic [CH_W-1:0] TAP_CH3    = 3'd2;
  localparam logic [CH_W-1:0] TAP_CH4    = 3'd3;
  localparam logic [CH_W-1:0] TAP_CH5    = 3'd4;
  localparam logic [CH_W-1:0] TAP_CH6    = 3'd5;
  localparam logic [CH_W-1:0] TAP_SPARE6 = 3'd6;
  localparam logic [CH_W-1:0] TAP_SPARE7 = 3'd7;

  // First address past the register map; writes there must be ignored.
  localparam logic [CFG_ADDR_W-1:0] UNUSED_ADDR = 5'd24;

  localparam int RANDOM_PHASES   = 6;
  localparam int ITEMS_PER_PHASE = 225;
  localparam int DRAIN_CYCLES    = 12;
  // Around 1400 transfers, each at worst behind a source gap, a sink stall
  // and the pipeline depth, stay well under this limit.
  localparam int RUN_LIMIT       = 400000;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [15:0]           in_tdata    = '0;   // [9:0] sample, rest zero
  logic [CH_W-1:0]       in_tuser    = '0;   // [2:0] channel
  logic                  out_tvalid;
  logic                  out_tready  = 1'b1;
  logic [23:0]           out_tdata;          // [15:0] average_mv, [18:16] cell_count
  logic [CH_W-1:0]       out_tuser;          // [2:0] channel_out
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  int failures;
  int pending;
  int cycle_count   = 0;
  int stall_left    = 0;
  // Percentages of transfers preceded by a source gap, and of cycles that
  // open a sink stall. Both are changed per phase; zero means no idling.
  int in_gap_pct    = 0;
  int out_stall_pct = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  cell_tap_averager_with_count DUT (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_prdata, .cfg_pready
  );

  tap_average_checker u_checker (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_pready,
    .failures, .pending
  );

  // Sink side: at random, ready drops for a burst of random length. A burst
  // once started runs to its end, even if the phase changes meanwhile.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= (stall_left == 1);
    end else if (rst_n && $urandom_range(0, 99) < out_stall_pct) begin
      stall_left <= $urandom_range(1, 19);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Watchdog: a hung handshake or a result that never comes ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("cell_tap_averager_with_count regression: fail");
      $finish;
    end
  end

  // Offers one sample and returns at the edge where the transfer happens.
  // A random gap may come first; valid then stays high until accepted.
  task automatic send_sample(input logic [CH_W-1:0] ch, input logic [SAMPLE_W-1:0] smp);
    if ($urandom_range(0, 99) < in_gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= ch;
    in_tdata  <= {{(16-SAMPLE_W){1'b0}}, smp};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Lowers valid and waits until every expected result has been seen. The
  // first edge is always waited out so that the checker has counted the
  // last transfer before the count is looked at.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Register write: setup, then access until pready.
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Writes the same scale to all six channels, with noise in the upper half
  // of the data word, which the register must drop.
  task automatic write_all_scales(input logic [SCALE_W-1:0] value);
    for (int i = 0; i < NUM_CH; i++)
      write_reg({cfg_idx_t'(i), 2'b00}, {16'($urandom), value});
  endtask

  initial begin : stimulus
    logic [CH_W-1:0]     ch;
    logic [CH_W-1:0]     last_ch;
    logic [SAMPLE_W-1:0] smp;
    logic [SCALE_W-1:0]  scale_pick;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, reset scales of 1.0: sample extremes on long and short
    // windows, then the unused channel codes, which must give a zero average.
    in_gap_pct    = 15;
    out_stall_pct = 15;
    send_sample(TAP_CH1, 10'd0);
    send_sample(TAP_CH1, 10'd1023);
    send_sample(TAP_CH2, 10'd512);
    send_sample(TAP_CH3, 10'd1023);
    send_sample(TAP_CH4, 10'd341);
    send_sample(TAP_CH5, 10'd1023);
    send_sample(TAP_CH6, 10'd1023);
    send_sample(TAP_SPARE6, 10'd1023);
    send_sample(TAP_SPARE7, 10'd0);
    send_sample(TAP_SPARE7, 10'd1023);
    send_sample(TAP_CH6, 10'd0);
    send_sample(TAP_CH5, 10'd1);
    wait_drained();

    // Largest scale: full-scale samples saturate the scaled value, and the
    // averages climb past each cell threshold in turn, then fall back as
    // the short window of channel 6 fills with zeros.
    write_all_scales(16'hFFFF);
    send_sample(TAP_CH3, 10'd1023);
    send_sample(TAP_CH3, 10'd1023);
    send_sample(TAP_CH4, 10'd1023);
    send_sample(TAP_CH4, 10'd1023);
    send_sample(TAP_CH5, 10'd1023);
    send_sample(TAP_CH6, 10'd1023);
    send_sample(TAP_SPARE6, 10'd5);
    send_sample(TAP_CH6, 10'd0);
    send_sample(TAP_CH6, 10'd0);
    send_sample(TAP_CH6, 10'd0);
    wait_drained();

    // Zero scale, plus a write beyond the register map that must change
    // nothing.
    write_all_scales(16'h0000);
    write_reg(UNUSED_ADDR, 32'h0000_1234);
    send_sample(TAP_CH1, 10'd1023);
    send_sample(TAP_CH5, 10'd1023);
    send_sample(TAP_CH4, 10'd682);

    // Random phases, each under its own scales and its own idling. Most
    // samples come in runs on one channel so that windows fill and the cell
    // count moves; a few use the unused codes.
    last_ch = TAP_CH1;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_drained();
      case (phase)
        0: begin in_gap_pct = 25; out_stall_pct = 25; end
        1: begin in_gap_pct = 0;  out_stall_pct = 40; end
        2: begin in_gap_pct = 40; out_stall_pct = 0;  end
        3: begin in_gap_pct = 10; out_stall_pct = 10; end
        4: begin in_gap_pct = 30; out_stall_pct = 30; end
        default: begin in_gap_pct = 0; out_stall_pct = 0; end
      endcase
      for (int i = 0; i < NUM_CH; i++) begin
        case ($urandom_range(0, 5))
          0:       scale_pick = 16'h0000;
          1:       scale_pick = 16'hFFFF;
          2:       scale_pick = SCALE_RESET;
          default: scale_pick = 16'($urandom);
        endcase
        write_reg({cfg_idx_t'(i), 2'b00}, {16'($urandom), scale_pick});
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(0, 99) < 8)
          ch = 3'($urandom_range(TAP_SPARE6, TAP_SPARE7));
        else if ($urandom_range(0, 99) < 55)
          ch = last_ch;
        else
          ch = 3'($urandom_range(TAP_CH1, TAP_CH6));
        case ($urandom_range(0, 9))
          0:       smp = '0;
          1:       smp = '1;
          2:       smp = 10'($urandom_range(900, 1023));
          default: smp = 10'($urandom);
        endcase
        send_sample(ch, smp);
        if (ch <= TAP_CH6) last_ch = ch;
      end
    end

    // Everything is in; let the results drain, then keep the clock running so
    // that any stray transfer shows.
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("cell_tap_averager_with_count regression: pass");
    end else begin
      $display("cell_tap_averager_with_count regression: fail");
    end
    $finish;
  end

endmodule
